/* rtl/mfb_pkg.sv */
// Shared types and constants for the monochrome framebuffer pixel writer.
package mfb_pkg;

    // Operation codes carried on the opcode field.
    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // Pattern step directions.
    typedef enum logic [1:0] {
        DIR_X_INC = 2'd0,
        DIR_Y_INC = 2'd1,
        DIR_X_DEC = 2'd2,
        DIR_Y_DEC = 2'd3
    } dir_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_VISIBLE_WIDTH   = 2'd0,
        CFG_FIRST_ROW       = 2'd1,
        CFG_LAST_ROW        = 2'd2,
        CFG_INVERT_POLARITY = 2'd3
    } cfg_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PLOT  = 6'b000010,
        S_CLEAR = 6'b000100,
        S_READ  = 6'b001000,
        S_RWAIT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [7:0] BYTE_ZEROS    = 8'h00;
    localparam logic [7:0] BYTE_ONES     = 8'hff;
    localparam logic [7:0] PIXEL_PATTERN = 8'h80;
    localparam logic [7:0] RST_VIS_WIDTH = 8'd128;
    localparam logic [5:0] RST_FIRST_ROW = 6'd0;
    localparam logic [5:0] RST_LAST_ROW  = 6'd63;
    localparam int         BYTE_ADDR_W   = 10;
    localparam int         ROW_BITS      = 3;
    localparam int         MAX_BANK      = 7;

endpackage

/* rtl/mfb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old content on a same-address write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/mono_framebuffer_pixel_writer.sv */
// Top level of the monochrome page-organized framebuffer pixel writer.
//
// Usage: one input channel (in_valid / in_stall) carries one command word per
// handshake: set one pixel, plot an 8-pixel pattern, clear the buffer, or read
// one buffer byte. Every command returns exactly one output word on
// (out_valid / out_stall); read_data holds the byte for a read, zero otherwise.
// The configuration port (cfg_write, cfg_index, cfg_data) writes the clip window
// and polarity; write it only while no command is in flight.
// Sequencing: a command is accepted only in the idle state. A pixel or pattern
// steps through S_PLOT once per pattern position up to and including the last
// set bit, then drains its last write; a read passes S_READ and S_RWAIT; a clear
// writes every byte in S_CLEAR. Each then loads the output word in S_DONE and
// returns to idle. The plot loop is bounded by the frame RAM: one read and one
// write port, one pixel issued per cycle with read-modify-write overlapped.
// Reset clears the sequencer, output valid and config registers to defaults;
// the frame RAM holds garbage until a clear command sweeps it, one byte a cycle.
// While the receiver stalls, the output word holds; a new command may still be
// accepted and runs to completion, then waits until the output register frees.
module mono_framebuffer_pixel_writer #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  x_coord,
    input  logic [7:0]  y_coord,
    input  logic        color,
    input  logic [7:0]  pattern,
    input  logic [1:0]  direction,
    input  logic [9:0]  byte_address,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    // configuration port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int STORE_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int STORE_W     = $clog2(STORE_BYTES + 1);
    // largest pixel address: x up to 255 plus bank up to 7 times the width
    localparam int PIX_SUM_W   = $clog2(256 + mfb_pkg::MAX_BANK * DISPLAY_WIDTH);
    localparam int CMP_A       = (PIX_SUM_W > STORE_W) ? PIX_SUM_W : STORE_W;
    localparam int CMP_W       = (CMP_A > mfb_pkg::BYTE_ADDR_W) ? CMP_A
                                                                 : mfb_pkg::BYTE_ADDR_W;

    // sequencer and command registers
    mfb_pkg::state_t state_reg, state_next;
    logic [7:0]      x_reg, x_next;
    logic [7:0]      y_reg, y_next;
    logic [7:0]      pat_reg, pat_next;
    mfb_pkg::dir_t   dir_reg, dir_next;
    logic            one_reg, one_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic            rd_range_reg, rd_range_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]      result_reg, result_next;

    // read-modify-write stage: pixel whose read is in flight
    logic              p1_valid_reg, p1_valid_next;
    logic [ADDR_W-1:0] p1_addr_reg, p1_addr_next;
    logic [mfb_pkg::ROW_BITS-1:0] p1_row_reg, p1_row_next;
    logic              p1_one_reg, p1_one_next;

    // last write, forwarded when the RAM read missed it
    logic              lw_valid_reg, lw_valid_next;
    logic [ADDR_W-1:0] lw_addr_reg, lw_addr_next;
    logic [7:0]        lw_data_reg, lw_data_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] read_data_reg, read_data_next;

    // configuration
    logic [7:0] vis_width_reg;
    logic [5:0] first_row_reg;
    logic [5:0] last_row_reg;
    logic       invert_reg;

    // RAM hookup
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    // datapath
    logic                 in_accept;
    logic [PIX_SUM_W-1:0] pix_sum;
    logic [CMP_W-1:0]     pix_cmp;
    logic [CMP_W-1:0]     byte_cmp;
    logic                 in_window;
    logic                 in_store;
    logic                 plot_hit;
    logic [7:0]           rmw_base;
    logic [7:0]           bit_mask;
    logic [7:0]           rmw_data;
    logic [7:0]           clear_byte;

    assign in_stall  = (state_reg != mfb_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    // Page layout: byte = x + (y / 8) * width from y bits 5:3; rows 64 and up are clipped.
    assign pix_sum = PIX_SUM_W'(x_reg)
                   + PIX_SUM_W'(y_reg[5:3]) * PIX_SUM_W'(DISPLAY_WIDTH);
    assign pix_cmp  = CMP_W'(pix_sum);
    assign byte_cmp = CMP_W'(byte_address);

    assign in_window = ({2'b00, first_row_reg} <= y_reg)
                    && (y_reg <= {2'b00, last_row_reg})
                    && (x_reg < vis_width_reg);
    assign in_store  = pix_cmp < CMP_W'(STORE_BYTES);
    assign plot_hit  = pat_reg[7] && in_window && in_store;

    // Take the previous cycle's write when the RAM read raced it.
    assign rmw_base = (lw_valid_reg && (lw_addr_reg == p1_addr_reg)) ? lw_data_reg
                                                                      : ram_rd_data;
    assign bit_mask = mfb_pkg::BYTE_ZEROS | (8'h01 << p1_row_reg);
    assign rmw_data = p1_one_reg ? (rmw_base | bit_mask) : (rmw_base & ~bit_mask);

    assign clear_byte = invert_reg ? mfb_pkg::BYTE_ONES : mfb_pkg::BYTE_ZEROS;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        pat_next       = pat_reg;
        dir_next       = dir_reg;
        one_next       = one_reg;
        rd_addr_next   = rd_addr_reg;
        rd_range_next  = rd_range_reg;
        clr_cnt_next   = clr_cnt_reg;
        result_next    = result_reg;
        p1_valid_next  = 1'b0;
        p1_addr_next   = p1_addr_reg;
        p1_row_next    = p1_row_reg;
        p1_one_next    = p1_one_reg;
        lw_valid_next  = p1_valid_reg;
        lw_addr_next   = p1_addr_reg;
        lw_data_next   = rmw_data;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;

        // finish the pending read-modify-write
        ram_wr_en   = p1_valid_reg;
        ram_wr_addr = p1_addr_reg;
        ram_wr_data = rmw_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = pix_cmp[ADDR_W-1:0];

        // drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            mfb_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    x_next        = x_coord;
                    y_next        = y_coord;
                    dir_next      = mfb_pkg::dir_t'(direction);
                    one_next      = color ^ invert_reg;
                    rd_addr_next  = byte_cmp[ADDR_W-1:0];
                    rd_range_next = byte_cmp < CMP_W'(STORE_BYTES);
                    clr_cnt_next  = '0;
                    result_next   = mfb_pkg::BYTE_ZEROS;
                    unique case (mfb_pkg::op_t'(opcode))
                        mfb_pkg::OP_PIXEL:
                        begin
                            pat_next   = mfb_pkg::PIXEL_PATTERN;
                            state_next = mfb_pkg::S_PLOT;
                        end
                        mfb_pkg::OP_PATTERN:
                        begin
                            pat_next   = pattern;
                            state_next = mfb_pkg::S_PLOT;
                        end
                        mfb_pkg::OP_CLEAR:
                        begin
                            state_next = mfb_pkg::S_CLEAR;
                        end
                        mfb_pkg::OP_READ:
                        begin
                            state_next = mfb_pkg::S_READ;
                        end
                        default:
                        begin
                            state_next = mfb_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            mfb_pkg::S_PLOT:
            begin
                if (pat_reg == mfb_pkg::BYTE_ZEROS)
                begin
                    // no set bits left; the last write drains this cycle
                    state_next = mfb_pkg::S_DONE;
                end
                else
                begin
                    ram_rd_en     = plot_hit;
                    p1_valid_next = plot_hit;
                    p1_addr_next  = pix_cmp[ADDR_W-1:0];
                    p1_row_next   = y_reg[mfb_pkg::ROW_BITS-1:0];
                    p1_one_next   = one_reg;
                    pat_next      = {pat_reg[6:0], 1'b0};
                    unique case (dir_reg)
                        mfb_pkg::DIR_X_INC: x_next = x_reg + 8'd1;
                        mfb_pkg::DIR_Y_INC: y_next = y_reg + 8'd1;
                        mfb_pkg::DIR_X_DEC: x_next = x_reg - 8'd1;
                        mfb_pkg::DIR_Y_DEC: y_next = y_reg - 8'd1;
                        default:            x_next = x_reg;
                    endcase
                end
            end

            mfb_pkg::S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = clear_byte;
                if (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = mfb_pkg::S_DONE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            mfb_pkg::S_READ:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = rd_addr_reg;
                state_next  = mfb_pkg::S_RWAIT;
            end

            mfb_pkg::S_RWAIT:
            begin
                result_next = rd_range_reg ? ram_rd_data : mfb_pkg::BYTE_ZEROS;
                state_next  = mfb_pkg::S_DONE;
            end

            mfb_pkg::S_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = result_reg;
                    state_next     = mfb_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mfb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfb_pkg::S_IDLE;
            p1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vis_width_reg <= mfb_pkg::RST_VIS_WIDTH;
            first_row_reg <= mfb_pkg::RST_FIRST_ROW;
            last_row_reg  <= mfb_pkg::RST_LAST_ROW;
            invert_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            lw_valid_reg  <= lw_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (mfb_pkg::cfg_t'(cfg_index))
                    mfb_pkg::CFG_VISIBLE_WIDTH:   vis_width_reg <= cfg_data;
                    mfb_pkg::CFG_FIRST_ROW:       first_row_reg <= cfg_data[5:0];
                    mfb_pkg::CFG_LAST_ROW:        last_row_reg  <= cfg_data[5:0];
                    mfb_pkg::CFG_INVERT_POLARITY: invert_reg    <= cfg_data[0];
                    default:                      invert_reg    <= invert_reg;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        pat_reg       <= pat_next;
        dir_reg       <= dir_next;
        one_reg       <= one_next;
        rd_addr_reg   <= rd_addr_next;
        rd_range_reg  <= rd_range_next;
        clr_cnt_reg   <= clr_cnt_next;
        result_reg    <= result_next;
        p1_addr_reg   <= p1_addr_next;
        p1_row_reg    <= p1_row_next;
        p1_one_reg    <= p1_one_next;
        lw_addr_reg   <= lw_addr_next;
        lw_data_reg   <= lw_data_next;
        read_data_reg <= read_data_next;
    end

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Every store write lands inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (CMP_W'(ram_wr_addr) < CMP_W'(STORE_BYTES)))
        else $error("frame write beyond store");

    // Writes come only from plotting (including its drain cycle) or clearing.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == mfb_pkg::S_PLOT || state_reg == mfb_pkg::S_CLEAR))
        else $error("frame write outside plot or clear");

    // A pending read-modify-write is always followed by its write in the plot loop.
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> (state_reg == mfb_pkg::S_PLOT && ram_wr_en))
        else $error("read-modify-write dropped");

    // An accepted command leaves idle on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != mfb_pkg::S_IDLE))
        else $error("accepted command not started");

endmodule

/* bench/mono_framebuffer_pixel_writer_tb.sv */
// Testbench for the monochrome framebuffer pixel writer: self-checking, random and directed.
`timescale 1ns / 100ps

module mono_framebuffer_pixel_writer_tb;

    localparam int DISP_W          = 128;
    localparam int DISP_H          = 64;
    localparam int STORE_BYTES     = DISP_W * DISP_H / 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 20;
    localparam int WATCHDOG_LIMIT  = 6000;

    // One command word as the sender presents it.
    typedef struct {
        mfb_pkg::op_t  op;
        logic [7:0]    x;
        logic [7:0]    y;
        logic          color;
        logic [7:0]    pattern;
        mfb_pkg::dir_t dir;
        logic [9:0]    addr;
    } command_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] opcode = mfb_pkg::OP_PIXEL;
    logic [7:0] x_coord = 8'd0;
    logic [7:0] y_coord = 8'd0;
    logic       color = 1'b0;
    logic [7:0] pattern = 8'd0;
    logic [1:0] direction = mfb_pkg::DIR_X_INC;
    logic [9:0] byte_address = 10'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = mfb_pkg::CFG_VISIBLE_WIDTH;
    logic [7:0] cfg_data = 8'd0;

    // Shadow copy of the frame and of the clip / polarity registers.
    logic [7:0] frame_model [0:STORE_BYTES-1];
    logic [7:0] vis_width_q;
    logic [5:0] first_row_q;
    logic [5:0] last_row_q;
    logic       invert_q;

    // Bytes the block still owes us, oldest first.
    logic [7:0] expected_bytes [$];

    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    // The long receiver hold-off is requested by flipping hold_toggle;
    // the receiver process owns the countdown.
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    mono_framebuffer_pixel_writer #(
        .DISPLAY_WIDTH  (DISP_W),
        .DISPLAY_HEIGHT (DISP_H)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .color        (color),
        .pattern      (pattern),
        .direction    (direction),
        .byte_address (byte_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Clip one pixel against width and row window, then update its bit.
    function automatic void plot_model_pixel(logic [7:0] x, logic [7:0] y, logic lit);
        int unsigned addr;
        logic        one;
        if (y < first_row_q || y > last_row_q || x >= vis_width_q)
            return;
        addr = x + (y >> 3) * DISP_W;
        if (addr >= STORE_BYTES)
            return;
        one = invert_q ? !lit : lit;
        frame_model[addr][y[2:0]] = one;
    endfunction

    // Apply one command to the shadow frame and return the word it produces.
    function automatic logic [7:0] predict_frame_word(command_t c);
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] pat;
        logic [7:0] word;
        x    = c.x;
        y    = c.y;
        pat  = c.pattern;
        word = mfb_pkg::BYTE_ZEROS;
        case (c.op)
            mfb_pkg::OP_PIXEL:
                plot_model_pixel(x, y, c.color);
            mfb_pkg::OP_PATTERN:
                for (int i = 0; i < 8; i++)
                begin
                    if (pat[7])
                        plot_model_pixel(x, y, c.color);
                    // Step with 8-bit wrap; wrapped pixels get clipped like any other.
                    case (c.dir)
                        mfb_pkg::DIR_X_INC: x = x + 8'd1;
                        mfb_pkg::DIR_Y_INC: y = y + 8'd1;
                        mfb_pkg::DIR_X_DEC: x = x - 8'd1;
                        default:            y = y - 8'd1;
                    endcase
                    pat = pat << 1;
                end
            mfb_pkg::OP_CLEAR:
                for (int a = 0; a < STORE_BYTES; a++)
                    frame_model[a] = invert_q ? mfb_pkg::BYTE_ONES : mfb_pkg::BYTE_ZEROS;
            default:
                if (c.addr < STORE_BYTES)
                    word = frame_model[c.addr];
        endcase
        return word;
    endfunction

    function automatic command_t make_command(mfb_pkg::op_t op, logic [7:0] x,
                                              logic [7:0] y, logic col, logic [7:0] pat,
                                              mfb_pkg::dir_t dir, logic [9:0] addr);
        command_t c;
        c.op      = op;
        c.x       = x;
        c.y       = y;
        c.color   = col;
        c.pattern = pat;
        c.dir     = dir;
        c.addr    = addr;
        return c;
    endfunction

    // Random command: mostly plots and reads near the visible window,
    // sometimes full-range coordinates, clears kept rare since they are slow.
    function automatic command_t random_command();
        command_t c;
        int       pick;
        pick      = int'($urandom_range(99));
        c.op      = (pick < 2)  ? mfb_pkg::OP_CLEAR :
                    (pick < 32) ? mfb_pkg::OP_PIXEL :
                    (pick < 66) ? mfb_pkg::OP_PATTERN : mfb_pkg::OP_READ;
        c.x       = ($urandom_range(3) != 0) ? 8'($urandom_range(int'(vis_width_q) + 7))
                                             : 8'($urandom_range(255));
        c.y       = ($urandom_range(3) != 0) ? 8'($urandom_range(71))
                                             : 8'($urandom_range(255));
        c.color   = 1'($urandom_range(1));
        c.pattern = 8'($urandom_range(255));
        c.dir     = mfb_pkg::dir_t'($urandom_range(3));
        // Aim half the reads at bytes that plots are likely to have touched.
        if ($urandom_range(1) != 0)
            c.addr = 10'($urandom_range(STORE_BYTES - 1));
        else
            c.addr = {c.y[5:3], c.x[6:0]};
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one command word; idle first at the current sender rate, then
    // hold the word until the block takes it. Entered and left at a rising edge.
    task automatic send_command(command_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= c.op;
        x_coord      <= c.x;
        y_coord      <= c.y;
        color        <= c.color;
        pattern      <= c.pattern;
        direction    <= c.dir;
        byte_address <= c.addr;
        do
            @(posedge clk);
        while (in_stall);
        expected_bytes.push_back(predict_frame_word(c));
    endtask

    // Stop offering, wait for every owed word, then let the block settle to idle.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; only call with the block idle.
    task automatic load_registers(logic [7:0] width, logic [5:0] first, logic [5:0] last,
                                  logic inv);
        cfg_write <= 1'b1;
        cfg_index <= mfb_pkg::CFG_VISIBLE_WIDTH;
        cfg_data  <= width;
        @(posedge clk);
        cfg_index <= mfb_pkg::CFG_FIRST_ROW;
        cfg_data  <= {2'b00, first};
        @(posedge clk);
        cfg_index <= mfb_pkg::CFG_LAST_ROW;
        cfg_data  <= {2'b00, last};
        @(posedge clk);
        cfg_index <= mfb_pkg::CFG_INVERT_POLARITY;
        cfg_data  <= {7'd0, inv};
        @(posedge clk);
        cfg_write <= 1'b0;
        vis_width_q = width;
        first_row_q = first;
        last_row_q  = last;
        invert_q    = inv;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall generation and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        $display("ERROR at %0t: %s: expected %02h, got %02h", $time, what, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        // Compare each accepted word against the oldest prediction.
        if (out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("word with nothing owed", mfb_pkg::BYTE_ZEROS, read_data);
            else
            begin
                logic [7:0] want;
                want = expected_bytes.pop_front();
                if (read_data !== want)
                    report_mismatch("read_data", want, read_data);
            end
        end
        // Start a long hold-off on request, else stall at the current rate.
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: count cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners, clipping, every pattern direction, wrap, zero pattern, reads.
    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        // Clear first: the frame holds garbage until swept.
        send_command(make_command(mfb_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd0, 8'd0, 1'b1, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd127, 8'd63, 1'b1, 8'hff,
                                  mfb_pkg::DIR_Y_DEC, 10'd1023));
        // Just outside the width and just below the last row: drop both.
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd128, 8'd5, 1'b1, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd5, 8'd64, 1'b1, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd255, 8'd255, 1'b1, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd1023));
        send_command(make_command(mfb_pkg::OP_PIXEL, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_READ, 8'd255, 8'd255, 1'b1, 8'hff,
                                  mfb_pkg::DIR_Y_DEC, 10'd0));
        // Patterns in all four directions, three of them wrapping through 255.
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd254, 8'd10, 1'b1, 8'hff,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd3, 8'd1, 1'b1, 8'ha5,
                                  mfb_pkg::DIR_Y_DEC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd60, 8'd20, 1'b1, 8'h81,
                                  mfb_pkg::DIR_Y_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd2, 8'd30, 1'b1, 8'hff,
                                  mfb_pkg::DIR_X_DEC, 10'd0));
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd1, 8'd10, 1'b0, 8'h5a,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        // Zero pattern: nothing lands.
        send_command(make_command(mfb_pkg::OP_PATTERN, 8'd10, 8'd10, 1'b1, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd0));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd128));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd133));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd3));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd316));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd444));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd385));
        send_command(make_command(mfb_pkg::OP_READ, 8'd0, 8'd0, 1'b0, 8'h00,
                                  mfb_pkg::DIR_X_INC, 10'd511));
    endtask

    // Walk several clip and polarity settings, extremes included.
    task automatic test_clip_windows();
        logic [5:0] first;
        send_idle_pct = 20;
        recv_idle_pct <= 20;
        for (int k = 0; k < 6; k++)
        begin
            wait_for_drain();
            case (k)
                0: load_registers(8'd0, 6'd0, 6'd63, 1'b0);     // zero width: drop all
                1: load_registers(8'd128, 6'd40, 6'd20, 1'b0);  // empty row window
                2: load_registers(8'd1, 6'd63, 6'd63, 1'b1);    // one column, one row
                3: load_registers(8'd128, 6'd0, 6'd63, 1'b1);   // inverted, full window
                4:
                begin
                    first = 6'($urandom_range(63));
                    load_registers(8'($urandom_range(128)), first,
                                   6'($urandom_range(63, int'(first))),
                                   1'($urandom_range(1)));
                end
                default: load_registers(8'd128, 6'd0, 6'd63, 1'b0);
            endcase
            // Sweep to ones under inverted polarity.
            if (k == 3)
                send_command(make_command(mfb_pkg::OP_CLEAR, 8'd0, 8'd0, 1'b1, 8'h00,
                                          mfb_pkg::DIR_X_INC, 10'd0));
            repeat (50) send_command(random_command());
        end
    endtask

    // Idle mixes: busy receiver with a quicker sender, the reverse, then none.
    task automatic test_idle_phases();
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct <= 75;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_idle_pct <= 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            repeat (130) send_command(random_command());
        end
    endtask

    // Hold the receiver off long enough to back the block up, keep offering, pause the
    // sender until every owed word has come, then send more to a half-stalling receiver.
    task automatic test_backpressure();
        wait_for_drain();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_toggle   <= ~hold_toggle;
        repeat (40) send_command(random_command());
        wait_for_drain();
        recv_idle_pct <= 50;
        repeat (20) send_command(random_command());
    endtask

    initial
    begin
        vis_width_q = mfb_pkg::RST_VIS_WIDTH;
        first_row_q = mfb_pkg::RST_FIRST_ROW;
        last_row_q  = mfb_pkg::RST_LAST_ROW;
        invert_q    = 1'b0;
        for (int a = 0; a < STORE_BYTES; a++)
            frame_model[a] = mfb_pkg::BYTE_ZEROS;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_clip_windows();
        test_idle_phases();
        test_backpressure();

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0)
            report_mismatch("word never delivered", expected_bytes[0], mfb_pkg::BYTE_ZEROS);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mfb_pkg.sv
rtl/mfb_ram.sv
rtl/mono_framebuffer_pixel_writer.sv
bench/mono_framebuffer_pixel_writer_tb.sv
